/* hdl/fpt_pkg.sv */
// shared types, codes and constants of the fan pwm and tach register block
`default_nettype none

package fpt_pkg;

  // register addresses on the bus side
  localparam logic [7:0] ADDR_DUTY  = 8'd0;
  localparam logic [7:0] ADDR_SPEED = 8'd1;

  // pwm period reset value (last count)
  localparam logic [7:0] PWM_TOP_RESET = 8'd159;

  // speed = 60 * 1000000 / 4 / interval, numerator fits in 24 bits
  localparam int unsigned NUM_BITS       = 24;
  localparam logic [NUM_BITS-1:0] SPEED_NUMERATOR = NUM_BITS'(60 * 1000000 / 4);
  localparam int unsigned DIV_CNT_W      = $clog2(NUM_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_BITS - 1);
  localparam logic [15:0] SPEED_SAT      = 16'hFFFF;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_PWM  = 1'b1;

  // input item command codes
  typedef enum logic [1:0] {
    CMD_BUS_WRITE = 2'd0,
    CMD_BUS_READ  = 2'd1,
    CMD_TACH_EDGE = 2'd2,
    CMD_PWM_TICK  = 2'd3
  } fpt_cmd_code_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SPEED,
    ST_SEND_LO,
    ST_SEND_LAST
  } fpt_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic bus_write;
    logic tach_edge;
    logic pwm_tick;
    logic read_duty;
    logic div_start;
    logic div_step;
    logic load_speed_lo;
    logic load_speed_hi;
  } fpt_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic ptr_duty;
    logic ptr_speed;
    logic div_done;
  } fpt_status_t;

endpackage

`default_nettype wire

/* hdl/fpt_ctrl.sv */
// controller state machine: accepts items and sequences reads and the divider
`default_nettype none

module fpt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_command,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire fpt_pkg::fpt_status_t status,
  output fpt_pkg::fpt_ctl_t        ctl
);

  fpt_pkg::fpt_state_t    state;
  fpt_pkg::fpt_state_t    state_next;
  fpt_pkg::fpt_cmd_code_t cmd_code;
  logic                   accept;

  assign cmd_code = fpt_pkg::fpt_cmd_code_t'(in_command);
  assign accept   = (state == fpt_pkg::ST_IDLE) && in_valid;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cmd_code)
            fpt_pkg::CMD_PWM_TICK: state_next = fpt_pkg::ST_SEND_LAST;
            fpt_pkg::CMD_BUS_READ: begin
              if (status.ptr_duty) begin
                state_next = fpt_pkg::ST_SEND_LAST;
              end else if (status.ptr_speed) begin
                state_next = fpt_pkg::ST_DIV;
              end
            end
            default: state_next = fpt_pkg::ST_IDLE;
          endcase
        end
      end
      fpt_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = fpt_pkg::ST_SPEED;
        end
      end
      fpt_pkg::ST_SPEED: state_next = fpt_pkg::ST_SEND_LO;
      fpt_pkg::ST_SEND_LO: begin
        if (out_ready) begin
          state_next = fpt_pkg::ST_SEND_LAST;
        end
      end
      fpt_pkg::ST_SEND_LAST: begin
        if (out_ready) begin
          state_next = fpt_pkg::ST_IDLE;
        end
      end
      default: state_next = fpt_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready  = (state == fpt_pkg::ST_IDLE);
    out_valid = (state == fpt_pkg::ST_SEND_LO) || (state == fpt_pkg::ST_SEND_LAST);
    ctl                = '0;
    ctl.bus_write      = accept && (cmd_code == fpt_pkg::CMD_BUS_WRITE);
    ctl.tach_edge      = accept && (cmd_code == fpt_pkg::CMD_TACH_EDGE);
    ctl.pwm_tick       = accept && (cmd_code == fpt_pkg::CMD_PWM_TICK);
    ctl.read_duty      = accept && (cmd_code == fpt_pkg::CMD_BUS_READ) && status.ptr_duty;
    ctl.div_start      = accept && (cmd_code == fpt_pkg::CMD_BUS_READ) &&
                         !status.ptr_duty && status.ptr_speed;
    ctl.div_step       = (state == fpt_pkg::ST_DIV);
    ctl.load_speed_lo  = (state == fpt_pkg::ST_SPEED);
    ctl.load_speed_hi  = (state == fpt_pkg::ST_SEND_LO) && out_ready;
  end

endmodule

`default_nettype wire

/* hdl/fpt_datapath.sv */
// datapath: registers, pwm counter, tach smoothing, serial divider, result register
`default_nettype none

module fpt_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data,
  input  wire logic [7:0]          reg_addr,
  input  wire logic                has_data,
  input  wire logic [7:0]          write_data,
  input  wire logic [31:0]         edge_time_us,
  input  wire fpt_pkg::fpt_ctl_t   ctl,
  output fpt_pkg::fpt_status_t     status,
  output logic                     out_kind,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic                     out_pwm_n
);

  logic [7:0]  pwm_top;
  logic [7:0]  reg_pointer;
  logic [7:0]  duty;
  logic [7:0]  pwm_count;
  logic [31:0] last_edge_time;
  logic [31:0] avg_interval;

  logic [31:0] gap;
  logic [31:0] avg_next;
  logic [7:0]  count_next;
  logic        tick_pwm_n;

  logic [fpt_pkg::NUM_BITS-1:0]  quot;
  logic [31:0]                   rem;
  logic [fpt_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [32:0]                   rem_sh;
  logic                          rem_ge;
  logic [31:0]                   rem_next;
  logic                          speed_sat;
  logic [15:0]                   speed;

  // pwm period register
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_top <= fpt_pkg::PWM_TOP_RESET;
    end else if (cfg_wr_en) begin
      pwm_top <= cfg_wr_data;
    end
  end

  // tach gap and smoothed interval
  assign gap      = edge_time_us - last_edge_time;
  assign avg_next = avg_interval - {2'b00, avg_interval[31:2]} + {2'b00, gap[31:2]};

  // pwm counter step and drive level
  always_comb begin
    count_next = (pwm_count >= pwm_top) ? 8'd0 : pwm_count + 8'd1;
    tick_pwm_n = (duty == 8'd0) ? 1'b1 : !(count_next < duty);
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_pointer    <= '0;
      duty           <= '0;
      pwm_count      <= '0;
      last_edge_time <= '0;
      avg_interval   <= '0;
    end else begin
      if (ctl.bus_write) begin
        reg_pointer <= reg_addr;
        if ((reg_addr == fpt_pkg::ADDR_DUTY) && has_data) begin
          duty <= write_data;
          if (write_data != 8'd0) begin
            pwm_count <= '0;
          end
        end
      end
      if (ctl.tach_edge) begin
        avg_interval   <= avg_next;
        last_edge_time <= edge_time_us;
      end
      if (ctl.pwm_tick && (duty != 8'd0)) begin
        pwm_count <= count_next;
      end
    end
  end

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, quot[fpt_pkg::NUM_BITS-1]};
    rem_ge   = rem_sh >= {1'b0, avg_interval};
    rem_next = rem_ge ? 32'(rem_sh - {1'b0, avg_interval}) : rem_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctl.div_start) begin
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt + fpt_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      quot <= fpt_pkg::SPEED_NUMERATOR;
      rem  <= '0;
    end else if (ctl.div_step) begin
      quot <= {quot[fpt_pkg::NUM_BITS-2:0], rem_ge};
      rem  <= rem_next;
    end
  end

  // saturate on zero interval or a quotient above 16 bits
  assign speed_sat = (avg_interval == 32'd0) || (quot[fpt_pkg::NUM_BITS-1:16] != '0);
  assign speed     = speed_sat ? fpt_pkg::SPEED_SAT : quot[15:0];

  // result register
  always_ff @(posedge clk) begin
    if (ctl.pwm_tick) begin
      out_kind  <= fpt_pkg::KIND_PWM;
      out_byte  <= '0;
      out_last  <= 1'b0;
      out_pwm_n <= tick_pwm_n;
    end else if (ctl.read_duty) begin
      out_kind  <= fpt_pkg::KIND_READ;
      out_byte  <= duty;
      out_last  <= 1'b1;
      out_pwm_n <= 1'b0;
    end else if (ctl.load_speed_lo) begin
      out_kind  <= fpt_pkg::KIND_READ;
      out_byte  <= speed[7:0];
      out_last  <= 1'b0;
      out_pwm_n <= 1'b0;
    end else if (ctl.load_speed_hi) begin
      out_kind  <= fpt_pkg::KIND_READ;
      out_byte  <= speed[15:8];
      out_last  <= 1'b1;
      out_pwm_n <= 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    status.ptr_duty  = (reg_pointer == fpt_pkg::ADDR_DUTY);
    status.ptr_speed = (reg_pointer == fpt_pkg::ADDR_SPEED);
    status.div_done  = (div_cnt == fpt_pkg::DIV_LAST);
  end

endmodule

`default_nettype wire

/* hdl/fan_pwm_tach_register_block_core.sv */
// Fan controller register block: pwm fan drive and tachometer behind a two-register
// bus interface. One item is taken at a time. Bus writes and tach edges complete on
// acceptance and give no result. A pwm tick or a read of the duty register gives one
// result item in the cycle after acceptance; the next item is taken the cycle after that
// item is delivered. A read of the speed register runs a serial restoring divider of
// 15000000 by the smoothed tach interval, one quotient bit per cycle, then loads the
// low byte, then delivers the low and high byte as two items. The speed saturates
// to 65535.
`default_nettype none

module fan_pwm_tach_register_block_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,   // pwm_top
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // reg_addr[7:0], has_data[8], write_data[16:9],
                                          // edge_time_us[48:17], zero fill
  input  wire logic [1:0]  s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // read_byte[7:0], pwm_n[8], zero fill
  output logic             m_axis_tlast,  // last_byte
  output logic             m_axis_tuser   // result_kind
);

  fpt_pkg::fpt_ctl_t    ctl;
  fpt_pkg::fpt_status_t status;
  logic [7:0]           out_byte;
  logic                 out_pwm_n;

  // controller
  fpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .status     (status),
    .ctl        (ctl)
  );

  // datapath
  fpt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .reg_addr     (s_axis_tdata[7:0]),
    .has_data     (s_axis_tdata[8]),
    .write_data   (s_axis_tdata[16:9]),
    .edge_time_us (s_axis_tdata[48:17]),
    .ctl          (ctl),
    .status       (status),
    .out_kind     (m_axis_tuser),
    .out_byte     (out_byte),
    .out_last     (m_axis_tlast),
    .out_pwm_n    (out_pwm_n)
  );

  // result packing
  assign m_axis_tdata = {7'b0, out_pwm_n, out_byte};

`ifndef SYNTHESIS
  // input and output sides are never open together in this sequencer
  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // a pwm result never marks the last byte of a read
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == fpt_pkg::KIND_PWM)) |-> !m_axis_tlast)
    else $error("pwm result marked as last read byte");

  // a pwm result carries no read byte
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == fpt_pkg::KIND_PWM)) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("pwm result with nonzero read byte");

  // input is not ready once a speed read has started the divider
  assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |=> !s_axis_tready)
    else $error("input taken while divider busy");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_fan_pwm_tach_register_block_core.sv */
`timescale 1ns / 1ps
// self-checking testbench for the fan pwm and tach register block core

module tb_fan_pwm_tach_register_block_core;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 115;
  localparam int NUM_PHASES     = 6;

  typedef struct packed {
    fpt_pkg::fpt_cmd_code_t cmd;
    logic [7:0]             addr;
    logic                   has_data;
    logic [7:0]             wdata;
    logic [31:0]            etime;
  } fan_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rbyte;
    logic       last;
    logic       pwm_n;
  } fan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = fpt_pkg::CMD_BUS_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // items waiting to be sent and results the block still owes
  fan_item_t   stim_q[$];
  fan_result_t expected_out_q[$];

  // shadow of the block state
  logic [7:0]  m_top = fpt_pkg::PWM_TOP_RESET;
  logic [7:0]  m_ptr = 8'd0;
  logic [7:0]  m_duty = 8'd0;
  logic [7:0]  m_count = 8'd0;
  logic [31:0] m_last_edge = 32'd0;
  logic [31:0] m_avg = 32'd0;

  int unsigned issued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned speed_reads = 0;
  int unsigned speed_sat = 0;
  int unsigned top_writes = 0;
  int unsigned idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          drain_hold = 1'b0;
  logic [31:0] tach_clock = 32'h0000_0010;
  fan_item_t   next_item;
  fan_item_t   seen_item;

  fan_pwm_tach_register_block_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic fan_result_t make_result(logic kind, logic [7:0] b, logic last,
                                              logic pwm_n);
    fan_result_t r;
    r.kind  = kind;
    r.rbyte = b;
    r.last  = last;
    r.pwm_n = pwm_n;
    return r;
  endfunction

  // advance the shadow state by one item and queue the results it causes
  task predict_fan_response(input fan_item_t it);
    logic [31:0] gap;
    logic [31:0] quo;
    logic [15:0] speed;
    case (it.cmd)
      fpt_pkg::CMD_BUS_WRITE: begin
        m_ptr = it.addr;
        if (it.addr == fpt_pkg::ADDR_DUTY && it.has_data) begin
          m_duty = it.wdata;
          if (it.wdata != 8'd0) m_count = 8'd0;
        end
      end
      fpt_pkg::CMD_BUS_READ: begin
        if (m_ptr == fpt_pkg::ADDR_DUTY) begin
          expected_out_q.push_back(make_result(fpt_pkg::KIND_READ, m_duty, 1'b1, 1'b0));
        end else if (m_ptr == fpt_pkg::ADDR_SPEED) begin
          if (m_avg == 32'd0) begin
            speed = fpt_pkg::SPEED_SAT;
          end else begin
            quo = {8'd0, fpt_pkg::SPEED_NUMERATOR} / m_avg;
            speed = (quo > 32'h0000_FFFF) ? fpt_pkg::SPEED_SAT : quo[15:0];
          end
          speed_reads++;
          if (speed == fpt_pkg::SPEED_SAT) speed_sat++;
          expected_out_q.push_back(make_result(fpt_pkg::KIND_READ, speed[7:0], 1'b0, 1'b0));
          expected_out_q.push_back(make_result(fpt_pkg::KIND_READ, speed[15:8], 1'b1, 1'b0));
        end
      end
      fpt_pkg::CMD_TACH_EDGE: begin
        // gap is modulo 2^32, so a wrapped timestamp still gives the true gap
        gap = it.etime - m_last_edge;
        m_avg = m_avg - (m_avg >> 2) + (gap >> 2);
        m_last_edge = it.etime;
      end
      default: begin
        if (m_duty == 8'd0) begin
          expected_out_q.push_back(make_result(fpt_pkg::KIND_PWM, 8'd0, 1'b0, 1'b1));
        end else begin
          m_count = (m_count >= m_top) ? 8'd0 : m_count + 8'd1;
          expected_out_q.push_back(make_result(fpt_pkg::KIND_PWM, 8'd0, 1'b0,
                                               (m_count < m_duty) ? 1'b0 : 1'b1));
        end
      end
    endcase
  endtask

  task check_result();
    fan_result_t want;
    if (expected_out_q.size() == 0) begin
      report_mismatch("result with nothing expected", m_axis_tdata, 32'd0);
    end else begin
      want = expected_out_q.pop_front();
      if (m_axis_tuser !== want.kind) report_mismatch("result_kind", m_axis_tuser, want.kind);
      if (m_axis_tdata[7:0] !== want.rbyte)
        report_mismatch("read_byte", m_axis_tdata[7:0], want.rbyte);
      if (m_axis_tlast !== want.last) report_mismatch("last_byte", m_axis_tlast, want.last);
      if (m_axis_tdata[8] !== want.pwm_n) report_mismatch("pwm_n", m_axis_tdata[8], want.pwm_n);
    end
  endtask

  // monitor: results are checked before the item taken on the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        results_seen++;
        check_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        taken_cnt++;
        seen_item.cmd      = fpt_pkg::fpt_cmd_code_t'(s_axis_tuser);
        seen_item.addr     = s_axis_tdata[7:0];
        seen_item.has_data = s_axis_tdata[8];
        seen_item.wdata    = s_axis_tdata[16:9];
        seen_item.etime    = s_axis_tdata[48:17];
        predict_fan_response(seen_item);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // driver: holds an item until taken, idles at random, sometimes waits for results
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!(s_axis_tvalid && taken_cnt != issued_cnt)) begin
        if (drain_hold && expected_out_q.size() == 0) drain_hold = 1'b0;
        if (!drain_hold && stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = stim_q.pop_front();
          s_axis_tuser  <= next_item.cmd;
          s_axis_tdata  <= {7'd0, next_item.etime, next_item.wdata, next_item.has_data,
                            next_item.addr};
          s_axis_tvalid <= 1'b1;
          issued_cnt++;
          if (issued_cnt == 300 || $urandom_range(149) == 0) drain_hold = 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task queue_item(input fpt_pkg::fpt_cmd_code_t cmd, input logic [7:0] addr, input logic hd,
                  input logic [7:0] wd, input logic [31:0] t);
    fan_item_t it;
    it.cmd      = cmd;
    it.addr     = addr;
    it.has_data = hd;
    it.wdata    = wd;
    it.etime    = t;
    stim_q.push_back(it);
  endtask

  function automatic fan_item_t random_fields(fpt_pkg::fpt_cmd_code_t cmd);
    fan_item_t it;
    it.cmd      = cmd;
    it.addr     = 8'($urandom);
    it.has_data = 1'($urandom);
    it.wdata    = 8'($urandom);
    it.etime    = $urandom;
    return it;
  endfunction

  // one short, mostly well-formed access sequence with random content
  task add_sequence();
    fan_item_t   it;
    int          pick;
    int          profile;
    int          n;
    logic [31:0] gap;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // duty update followed by a run of ticks and sometimes a read
      it = random_fields(fpt_pkg::CMD_BUS_WRITE);
      it.addr = fpt_pkg::ADDR_DUTY;
      it.has_data = ($urandom_range(5) != 0);
      case ($urandom_range(7))
        0: it.wdata = 8'd0;
        1: it.wdata = m_top + 8'd1;
        2: it.wdata = 8'hFF;
        default: it.wdata = 8'($urandom_range(255));
      endcase
      stim_q.push_back(it);
      n = $urandom_range(2, 12);
      repeat (n) stim_q.push_back(random_fields(fpt_pkg::CMD_PWM_TICK));
      if ($urandom_range(1) == 0) stim_q.push_back(random_fields(fpt_pkg::CMD_BUS_READ));
    end else if (pick < 60) begin
      // point at speed, feed tach edges, read the speed
      it = random_fields(fpt_pkg::CMD_BUS_WRITE);
      it.addr = fpt_pkg::ADDR_SPEED;
      stim_q.push_back(it);
      profile = $urandom_range(9);
      n = (profile < 2) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      repeat (n) begin
        if (profile < 2) gap = $urandom_range(250);
        else if (profile < 8) gap = $urandom_range(60000, 3000);
        else gap = $urandom;
        tach_clock = tach_clock + gap;
        it = random_fields(fpt_pkg::CMD_TACH_EDGE);
        it.etime = tach_clock;
        stim_q.push_back(it);
      end
      stim_q.push_back(random_fields(fpt_pkg::CMD_BUS_READ));
    end else if (pick < 75) begin
      // noise: any command, any fields
      stim_q.push_back(random_fields(fpt_pkg::fpt_cmd_code_t'($urandom_range(3))));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) stim_q.push_back(random_fields(fpt_pkg::CMD_PWM_TICK));
    end
  endtask

  // wait until everything sent was taken and answered, then let the block settle
  task wait_drained();
    while (stim_q.size() != 0 || taken_cnt != issued_cnt || expected_out_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_pwm_top(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_top = value;
    top_writes++;
  endtask

  // main sequence
  initial begin
    int         phase;
    logic [7:0] top_val;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 53;

    // directed: stopped tick, duty and speed reads, zero and tiny interval, wrap
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_WRITE, fpt_pkg::ADDR_SPEED, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_TACH_EDGE, 8'd0, 1'b0, 8'd0, 32'd100);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_TACH_EDGE, 8'd0, 1'b0, 8'd0, 32'hFFFF_FFFF);
    queue_item(fpt_pkg::CMD_TACH_EDGE, 8'd0, 1'b0, 8'd0, 32'h0000_0010);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    // duty above top, write without data, small duty
    queue_item(fpt_pkg::CMD_BUS_WRITE, fpt_pkg::ADDR_DUTY, 1'b1, 8'hFF, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_WRITE, fpt_pkg::ADDR_DUTY, 1'b0, 8'h40, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_WRITE, fpt_pkg::ADDR_DUTY, 1'b1, 8'd2, 32'd0);
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    // unknown register: pointer only, read gives nothing
    queue_item(fpt_pkg::CMD_BUS_WRITE, 8'hFF, 1'b1, 8'hAA, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    // stop the fan, then data to the speed register
    queue_item(fpt_pkg::CMD_BUS_WRITE, fpt_pkg::ADDR_DUTY, 1'b1, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_PWM_TICK,  8'd0, 1'b0, 8'd0, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_WRITE, fpt_pkg::ADDR_SPEED, 1'b1, 8'h55, 32'd0);
    queue_item(fpt_pkg::CMD_BUS_READ,  8'd0, 1'b0, 8'd0, 32'd0);
    wait_drained();

    // random phases over several pwm_top settings and idle patterns
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 53;
        recv_idle_pct = 11;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: top_val = 8'd0;
        1: top_val = 8'd255;
        2: top_val = 8'd1;
        4: top_val = fpt_pkg::PWM_TOP_RESET;
        default: top_val = 8'($urandom_range(255));
      endcase
      write_pwm_top(top_val);
      while (stim_q.size() < PHASE_ITEMS) add_sequence();
      wait_drained();
    end

    $display("run: %0d items taken, %0d results checked, %0d pwm_top writes",
             taken_cnt, results_seen, top_writes);
    $display("run: %0d speed reads, %0d of them saturated", speed_reads, speed_sat);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
